// ----- rtl/lptt_pkg.sv -----
// shared types, command codes and helper functions of the lcd page tile transposer
package lptt_pkg;

   localparam int PAGES           = 8;
   localparam int GROUPS_PER_PAGE = 16;

   // longest burst of bytes caused by one item: three address commands and eight data bytes
   localparam int FRAME_MAX   = 11;
   localparam int COUNT_W     = 4;
   localparam int REQ_DATA_W  = 80;
   localparam int GROUP_CMP_W = 6;

   localparam logic [3:0]             PAGE_LIMIT  = 4'(PAGES);
   localparam logic [GROUP_CMP_W-1:0] GROUP_LIMIT = GROUP_CMP_W'(GROUPS_PER_PAGE);

   localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
   localparam logic [7:0] CMD_COL_LOW   = 8'h04;
   localparam logic [7:0] CMD_CONTRAST  = 8'h81;

   typedef enum logic [1:0] {
      ACT_TILE     = 2'd0,
      ACT_CONTRAST = 2'd1,
      ACT_INIT     = 2'd2
   } action_type;

   typedef struct packed {
      logic [1:0]      action;
      logic [2:0]      page;
      logic [3:0]      column_group;
      logic [7:0][7:0] lines;
      logic [7:0]      contrast_level;
   } req_item_type;

   // bytes[0] goes out first; data_flags marks data bytes
   typedef struct packed {
      logic [FRAME_MAX-1:0][7:0] bytes;
      logic [FRAME_MAX-1:0]      data_flags;
      logic [COUNT_W-1:0]        count;
   } frame_type;

   function automatic logic [7:0] init_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0: b = 8'h2F;
         3'd1: b = 8'h81;
         3'd2: b = 8'h15;
         3'd3: b = 8'hA2;
         3'd4: b = 8'hA1;
         3'd5: b = 8'hC0;
         3'd6: b = 8'hA4;
         3'd7: b = 8'hAF;
      endcase
      return b;
   endfunction

   // bit j of column byte s is bit s of line byte j
   function automatic logic [7:0][7:0] transpose(input logic [7:0][7:0] lines);
      logic [7:0][7:0] cols;
      for (int s = 0; s < 8; s++) begin
         for (int j = 0; j < 8; j++) begin
            cols[s][j] = lines[j][s];
         end
      end
      return cols;
   endfunction

endpackage

// ----- rtl/lptt_build.sv -----
// input stage: registers one item and builds the byte burst it causes
module lptt_build (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  lptt_pkg::req_item_type  req_item,
   output logic                    frame_valid,
   input  logic                    frame_ready,
   output lptt_pkg::frame_type     frame
);

   lptt_pkg::frame_type frame_in;
   lptt_pkg::frame_type frame_ff;
   logic                valid_ff;
   logic                valid_in;
   logic                accept;
   logic [7:0][7:0]     cols;
   logic                in_range;

   assign cols     = lptt_pkg::transpose(req_item.lines);
   assign in_range = ({1'b0, req_item.page} < lptt_pkg::PAGE_LIMIT) &&
                     ({2'b00, req_item.column_group} < lptt_pkg::GROUP_LIMIT);

   always_comb begin
      frame_in = '0;
      unique case (req_item.action)
         lptt_pkg::ACT_TILE: begin
            if (in_range) begin
               if (req_item.column_group == 4'd0) begin
                  frame_in.bytes[0]     = lptt_pkg::CMD_PAGE_BASE | {5'b00000, req_item.page};
                  frame_in.bytes[1]     = lptt_pkg::CMD_COL_HIGH;
                  frame_in.bytes[2]     = lptt_pkg::CMD_COL_LOW;
                  frame_in.bytes[10:3]  = cols;
                  frame_in.data_flags   = 11'b111_1111_1000;
                  frame_in.count        = lptt_pkg::COUNT_W'(lptt_pkg::FRAME_MAX);
               end else begin
                  frame_in.bytes[7:0]   = cols;
                  frame_in.data_flags   = 11'b000_1111_1111;
                  frame_in.count        = lptt_pkg::COUNT_W'(8);
               end
            end
         end
         lptt_pkg::ACT_CONTRAST: begin
            frame_in.bytes[0] = lptt_pkg::CMD_CONTRAST;
            frame_in.bytes[1] = {2'b00, req_item.contrast_level[7:2]};
            frame_in.count    = lptt_pkg::COUNT_W'(2);
         end
         lptt_pkg::ACT_INIT: begin
            for (int k = 0; k < 8; k++) begin
               frame_in.bytes[k] = lptt_pkg::init_byte(3'(k));
            end
            frame_in.count = lptt_pkg::COUNT_W'(8);
         end
         // unused action code: nothing goes out
         default: frame_in = '0;
      endcase
   end

   assign req_tready = !valid_ff || frame_ready;
   assign accept     = req_tvalid && req_tready;

   // items that cause no bytes are dropped here
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = (frame_in.count != '0);
      end else if (frame_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         frame_ff <= frame_in;
      end
   end

   assign frame_valid = valid_ff;
   assign frame       = frame_ff;

   a_held_frame_not_empty: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (frame_ff.count != '0))
      else $error("held frame has no bytes");

endmodule

// ----- rtl/lptt_serial.sv -----
// byte serializer with output register
module lptt_serial (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 frame_valid,
   output logic                 frame_ready,
   input  lptt_pkg::frame_type  frame,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tuser,
   output logic                 rsp_tlast
);

   logic [lptt_pkg::FRAME_MAX-1:0][7:0] bytes_ff;
   logic [lptt_pkg::FRAME_MAX-1:0][7:0] bytes_in;
   logic [lptt_pkg::FRAME_MAX-1:0]      flags_ff;
   logic [lptt_pkg::FRAME_MAX-1:0]      flags_in;
   logic [lptt_pkg::COUNT_W-1:0]        count_ff;
   logic [lptt_pkg::COUNT_W-1:0]        count_in;
   logic                                out_valid_ff;
   logic                                out_valid_in;
   logic [7:0]                          out_byte_ff;
   logic                                out_data_ff;
   logic                                out_last_ff;
   logic                                emit;
   logic                                emit_last;
   logic                                load;

   assign emit        = (count_ff != '0) && (!out_valid_ff || rsp_tready);
   assign emit_last   = emit && (count_ff == lptt_pkg::COUNT_W'(1));
   assign frame_ready = (count_ff == '0) || emit_last;
   assign load        = frame_valid && frame_ready;

   always_comb begin
      bytes_in = bytes_ff;
      flags_in = flags_ff;
      count_in = count_ff;
      if (load) begin
         bytes_in = frame.bytes;
         flags_in = frame.data_flags;
         count_in = frame.count;
      end else if (emit) begin
         bytes_in = {8'h00, bytes_ff[lptt_pkg::FRAME_MAX-1:1]};
         flags_in = {1'b0, flags_ff[lptt_pkg::FRAME_MAX-1:1]};
         count_in = count_ff - lptt_pkg::COUNT_W'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      flags_ff <= flags_in;
      if (emit) begin
         out_byte_ff <= bytes_ff[0];
         out_data_ff <= flags_ff[0];
         out_last_ff <= (count_ff == lptt_pkg::COUNT_W'(1));
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lptt_pkg::COUNT_W'(lptt_pkg::FRAME_MAX))
      else $error("byte count beyond burst length");

   a_last_on_final_byte: assert property (@(posedge clock) disable iff (reset)
      emit |=> (out_last_ff == ($past(count_ff) == lptt_pkg::COUNT_W'(1))))
      else $error("tlast does not match final byte");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> ((count_ff == '0) || emit_last) && (frame.count != '0))
      else $error("frame loaded over pending bytes");

endmodule

// ----- rtl/lcd_page_tile_transposer.sv -----
// top level of the lcd page tile transposer
//
// turns one 8x8 tile of a row-major 1-bit framebuffer, a contrast request or
// an init request into a stream of command and data bytes for a page-mode lcd
// controller. the req channel carries one item per handshake: tuser holds the
// action, tdata the page, column group, eight line bytes and contrast level.
// the rsp channel carries one byte per handshake, tuser high for a data byte
// (rs high) and low for a command byte, tlast on the final byte of an item.
// a tile gives eight data bytes, preceded by three address commands when its
// column group is zero; contrast gives two commands, init eight commands.
// unused action codes and tiles with page or group out of range give nothing.
// the first byte of an item passes through the input register, the burst register and
// the output byte register before it appears on rsp. throughput: one byte per cycle
// while rsp is not stalled; an item causes 2, 8 or 11 bytes. the input
// register takes the next item while the current burst is still going out.
// a stalled rsp holds its byte and backs up through the burst and input
// registers to req_tready. reset empties all stages and drops any burst.
module lcd_page_tile_transposer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // page[2:0], column_group[6:3], line_0..line_7[70:7], contrast_level[78:71], zero[79]
   input  logic [lptt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action[1:0]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_byte[7:0]
   output logic [7:0]                        rsp_tdata,
   // is_data[0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   lptt_pkg::req_item_type req_item;
   lptt_pkg::frame_type    frame;
   logic                   frame_valid;
   logic                   frame_ready;

   always_comb begin
      req_item.action         = req_tuser;
      req_item.page           = req_tdata[2:0];
      req_item.column_group   = req_tdata[6:3];
      req_item.lines          = req_tdata[70:7];
      req_item.contrast_level = req_tdata[78:71];
   end

   lptt_build u_build (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_item    (req_item),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame       (frame)
   );

   lptt_serial u_serial (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame       (frame),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
